FILE: sv/assert_macros.svh
// ============================================================================
// Assertion macros
// Clocked concurrent assertion helpers used by the queue core RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define APRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define APRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/aprq_pkg.sv
// ============================================================================
// aprq_pkg
// Shared types and constants of the affinity priority ready queue.
// ============================================================================
package aprq_pkg;

    localparam int PRI_W   = 15;
    localparam int AFF_W   = 8;
    localparam int CPU_W   = 3;
    localparam int ID_IN_W = 8;
    localparam int OCC_W   = 6;
    localparam int STAT_W  = 2;

    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int DEF_CPU_COUNT   = 8;
    localparam int DEF_ID_BITS     = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TAKE   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NOTFOUND = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_RSVD     = 2'd3
    } status_t;

    // Broadcast command from the controller to every cell.
    typedef struct packed {
        logic             capture;  // latch the per-cell match flag
        logic             apply;    // move the chain this cycle
        op_t              op;
        logic [PRI_W-1:0] pri;      // effective priority of the transaction
        logic [AFF_W-1:0] aff;
        logic [CPU_W-1:0] cpu;
        logic             cpu_ok;   // cpu number below the CPU count
    } cell_cmd_t;

endpackage

FILE: sv/aprq_cell.sv
// ============================================================================
// aprq_cell
// One queue slot: holds a task, latches its match flag and shifts data to or
// from its neighbors when the chain moves.
// ============================================================================
module aprq_cell
    import aprq_pkg::*;
#(
    parameter int ID_BITS = DEF_ID_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_cmd_t          cmd,
    input  logic [ID_BITS-1:0] cmd_id,
    // left neighbor (toward the head)
    input  logic               left_flag,
    input  logic               left_valid,
    input  logic [ID_BITS-1:0] left_task,
    input  logic [PRI_W-1:0]   left_pri,
    input  logic [AFF_W-1:0]   left_aff,
    // right neighbor (toward the tail)
    input  logic               right_valid,
    input  logic [ID_BITS-1:0] right_task,
    input  logic [PRI_W-1:0]   right_pri,
    input  logic [AFF_W-1:0]   right_aff,
    // hold on remove or take: this cell lies before the removed one
    input  logic               hold,
    output logic               flag,
    output logic               valid,
    output logic [ID_BITS-1:0] task_id,
    output logic [PRI_W-1:0]   pri,
    output logic [AFF_W-1:0]   aff,
    output logic               nxt_valid,
    output logic [PRI_W-1:0]   nxt_pri
);

    logic               valid_reg, valid_next;
    logic               flag_reg, flag_next;
    logic [ID_BITS-1:0] task_reg, task_next;
    logic [PRI_W-1:0]   pri_reg, pri_next;
    logic [AFF_W-1:0]   aff_reg, aff_next;

    always_comb
    begin
        valid_next = valid_reg;
        flag_next  = flag_reg;
        task_next  = task_reg;
        pri_next   = pri_reg;
        aff_next   = aff_reg;
        if (cmd.capture)
        begin
            unique case (cmd.op)
                OP_INSERT: flag_next = valid_reg && (pri_reg >= cmd.pri);
                OP_REMOVE: flag_next = valid_reg && (task_reg == cmd_id);
                OP_TAKE:   flag_next = valid_reg && cmd.cpu_ok && aff_reg[cmd.cpu];
                default:   flag_next = 1'b0;
            endcase
        end
        if (cmd.apply)
        begin
            case (cmd.op) inside
                OP_INSERT:
                begin
                    // keep cells stay; the first other cell takes the new task
                    if (!flag_reg)
                    begin
                        if (left_flag)
                        begin
                            valid_next = 1'b1;
                            task_next  = cmd_id;
                            pri_next   = cmd.pri;
                            aff_next   = cmd.aff;
                        end
                        else
                        begin
                            valid_next = left_valid;
                            task_next  = left_task;
                            pri_next   = left_pri;
                            aff_next   = left_aff;
                        end
                    end
                end
                OP_REMOVE, OP_TAKE:
                begin
                    if (!hold)
                    begin
                        valid_next = right_valid;
                        task_next  = right_task;
                        pri_next   = right_pri;
                        aff_next   = right_aff;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg <= task_next;
        pri_reg  <= pri_next;
        aff_reg  <= aff_next;
    end

    assign flag      = flag_reg;
    assign valid     = valid_reg;
    assign task_id   = task_reg;
    assign pri       = pri_reg;
    assign aff       = aff_reg;
    assign nxt_valid = valid_next;
    assign nxt_pri   = pri_next;

endmodule

FILE: sv/affinity_priority_ready_queue_core.sv
// ============================================================================
// affinity_priority_ready_queue_core
// Ready queue of tasks sorted by falling priority, held in a chain of cells.
// ============================================================================
//
//  Channel  Signals                    Direction  Carries
//  -------  -------------------------  ---------  ---------------------------
//  s_*      s_tvalid s_tready s_tdata  in         one command (insert/remove/
//           s_tuser                               take) per transaction
//  m_*      m_tvalid m_tready m_tdata  out        one result per command
//
//  On accept every cell latches a match flag (priority compare, id compare
//  or affinity bit); the shift cycle then loads the output register and,
//  where the command changes the queue, moves the chain by one place.
//  A result waiting in the output register does not block the accept of the
//  next command; that command stalls in its shift cycle until the result is
//  taken. Reset empties the queue at once (cell valid and flag bits only).
//
`include "assert_macros.svh"

module affinity_priority_ready_queue_core
    import aprq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int CPU_COUNT   = DEF_CPU_COUNT,
    parameter int ID_BITS     = DEF_ID_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] task_id, [22:8] priority_req, [23] realtime_req,
    // [38:24] rt_priority, [46:39] affinity, [49:47] cpu, [55:50] zero
    input  logic [55:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [9:2] taken_id, [24:10] used_priority,
    // [39:25] head_priority, [45:40] occupancy, [47:46] zero
    output logic [47:0] m_tdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_APPLY = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // latched command
    op_t                op_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [PRI_W-1:0]   pri_reg;
    logic [AFF_W-1:0]   aff_reg;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [47:0]        out_data_reg, out_data_next;

    // unpacked input fields
    op_t                in_op;
    logic [ID_BITS-1:0] in_id;
    logic [PRI_W-1:0]   in_pri;
    logic [AFF_W-1:0]   in_aff;
    logic [CPU_W-1:0]   in_cpu;

    cell_cmd_t          cmd;
    logic [ID_BITS-1:0] cmd_id;
    logic               accept;
    logic               stall;
    logic               do_apply;
    logic               full;

    // chain wiring
    logic               c_flag  [QUEUE_DEPTH];
    logic               c_valid [QUEUE_DEPTH];
    logic [ID_BITS-1:0] c_task  [QUEUE_DEPTH];
    logic [PRI_W-1:0]   c_pri   [QUEUE_DEPTH];
    logic [AFF_W-1:0]   c_aff   [QUEUE_DEPTH];
    logic               c_nvalid[QUEUE_DEPTH];
    logic [PRI_W-1:0]   c_npri  [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] match_vec;
    logic [QUEUE_DEPTH-1:0] first_hot;
    logic [QUEUE_DEPTH-1:0] before_vec;
    logic [QUEUE_DEPTH-1:0] valid_vec;
    logic [QUEUE_DEPTH-2:0] order_err;
    logic                   found;
    logic [ID_BITS-1:0]     sel_task;
    logic [PRI_W-1:0]       sel_pri;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign in_op  = op_t'(s_tuser);
    assign in_id  = ID_BITS'(s_tdata[7:0]);
    assign in_pri = s_tdata[23] ? s_tdata[38:24] : s_tdata[22:8];
    assign in_aff = s_tdata[46:39];
    assign in_cpu = s_tdata[49:47];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign stall    = out_valid_reg && !m_tready;
    assign do_apply = (state_reg == ST_APPLY) && !stall;
    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));

    // Capture uses the live input; the shift cycle uses the latched command.
    always_comb
    begin
        cmd.capture = accept;
        cmd.apply   = do_apply && !((op_reg == OP_INSERT) && full);
        cmd.cpu     = in_cpu;
        cmd.cpu_ok  = (32'(in_cpu) < CPU_COUNT);
        if (state_reg == ST_IDLE)
        begin
            cmd.op = in_op;
            cmd.pri = in_pri;
            cmd.aff = in_aff;
            cmd_id = in_id;
        end
        else
        begin
            cmd.op = op_reg;
            cmd.pri = pri_reg;
            cmd.aff = aff_reg;
            cmd_id = id_reg;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: cell 0 is the head
    // ------------------------------------------------------------------
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic               l_flag, l_valid, r_valid;
        logic [ID_BITS-1:0] l_task, r_task;
        logic [PRI_W-1:0]   l_pri, r_pri;
        logic [AFF_W-1:0]   l_aff, r_aff;

        if (i == 0)
        begin : g_head
            assign l_flag  = 1'b1;
            assign l_valid = 1'b0;
            assign l_task  = '0;
            assign l_pri   = '0;
            assign l_aff   = '0;
        end
        else
        begin : g_mid
            assign l_flag  = c_flag[i-1];
            assign l_valid = c_valid[i-1];
            assign l_task  = c_task[i-1];
            assign l_pri   = c_pri[i-1];
            assign l_aff   = c_aff[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_task  = '0;
            assign r_pri   = '0;
            assign r_aff   = '0;
        end
        else
        begin : g_body
            assign r_valid = c_valid[i+1];
            assign r_task  = c_task[i+1];
            assign r_pri   = c_pri[i+1];
            assign r_aff   = c_aff[i+1];
        end

        aprq_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .cmd_id      (cmd_id),
            .left_flag   (l_flag),
            .left_valid  (l_valid),
            .left_task   (l_task),
            .left_pri    (l_pri),
            .left_aff    (l_aff),
            .right_valid (r_valid),
            .right_task  (r_task),
            .right_pri   (r_pri),
            .right_aff   (r_aff),
            .hold        (before_vec[i]),
            .flag        (c_flag[i]),
            .valid       (c_valid[i]),
            .task_id     (c_task[i]),
            .pri         (c_pri[i]),
            .aff         (c_aff[i]),
            .nxt_valid   (c_nvalid[i]),
            .nxt_pri     (c_npri[i])
        );

        assign match_vec[i] = c_flag[i];
        assign valid_vec[i] = c_valid[i];

        if (i < QUEUE_DEPTH - 1)
        begin : g_order
            assign order_err[i] = c_valid[i+1] && (c_pri[i+1] > c_pri[i]);
        end
    end

    // Isolate the first match; every cell ahead of it holds, the rest pull
    // from the right. No match gives all ones, so the chain holds.
    assign first_hot  = match_vec & (~match_vec + 1'b1);
    assign before_vec = first_hot - 1'b1;
    assign found      = |match_vec;

    always_comb
    begin
        sel_task = '0;
        sel_pri  = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (first_hot[i])
            begin
                sel_task = sel_task | c_task[i];
                sel_pri  = sel_pri | c_pri[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result and count
    // ------------------------------------------------------------------
    always_comb
    begin
        status_t          st;
        logic [ID_IN_W-1:0] taken;
        logic [PRI_W-1:0] used;
        logic [PRI_W-1:0] head;

        st       = STAT_OK;
        taken    = '0;
        used     = '0;
        cnt_next = cnt_reg;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (full)
                begin
                    st = STAT_FULL;
                end
                else
                begin
                    used     = pri_reg;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (found)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    st = STAT_NOTFOUND;
                end
            end
            OP_TAKE:
            begin
                if (found)
                begin
                    taken    = ID_IN_W'(sel_task);
                    used     = sel_pri;
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    st = STAT_NOTFOUND;
                end
            end
            default:
            begin
            end
        endcase
        head = c_nvalid[0] ? c_npri[0] : '0;
        out_data_next = {2'b00, OCC_W'(cnt_next), head, used, taken, st};
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (!stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (do_apply)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // Latch the command on accept; load the result in each unstalled shift cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= in_op;
            id_reg  <= in_id;
            pri_reg <= in_pri;
            aff_reg <= in_aff;
        end
        if (do_apply)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `APRQ_ASSERT(a_valid_prefix, clk, rst_n, ((valid_vec + 1'b1) & valid_vec) == '0, "valid cells are not a prefix")
    `APRQ_ASSERT(a_count_match, clk, rst_n, 32'(cnt_reg) == $countones(valid_vec), "count differs from valid cells")
    `APRQ_ASSERT(a_sorted, clk, rst_n, order_err == '0, "queue not sorted by falling priority")
    `APRQ_ASSERT_NEXT(a_accept_apply, clk, rst_n, accept, state_reg == ST_APPLY, "accept did not enter shift cycle")
    `APRQ_ASSERT_NEXT(a_result_out, clk, rst_n, do_apply, m_tvalid, "shift cycle produced no result")

endmodule

FILE: tb/sv/affinity_priority_ready_queue_core_tb.sv
// ============================================================================
// affinity_priority_ready_queue_core_tb
// Self-checking bench for the affinity priority ready queue. A directed
// opening and phased random command streams are checked result by result
// against a behavioral copy of the queue, with random stalls on both sides.
// ============================================================================
module affinity_priority_ready_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aprq_pkg::*;

    localparam int QDEPTH      = DEF_QUEUE_DEPTH;
    localparam int CPUS        = DEF_CPU_COUNT;
    localparam logic [ID_IN_W-1:0] ID_MASK = ID_IN_W'((1 << DEF_ID_BITS) - 1);

    localparam int N_RANDOM    = 1834;   // random commands after the directed opening
    localparam int PHASE_LEN   = 90;     // commands per fill / drain / mixed phase
    localparam int IDLE_PCT    = 14;     // chance of a gap or stall per cycle, in percent
    localparam int CALM_FROM   = 600;    // window with no gaps and no stalls on either side
    localparam int CALM_TO     = 1100;
    localparam int HOLD_AT_A   = 1500;   // cycles at which the sink starts a long hold-off
    localparam int HOLD_AT_B   = 3000;
    localparam int HOLD_LEN    = 120;
    localparam int TAIL_CYCLES = 12;     // settle time after the last result
    localparam int LIMIT_NS    = 5_000_000;

    // One command as offered on the slave side.
    typedef struct {
        op_t                op;
        logic [ID_IN_W-1:0] task_id;
        logic [PRI_W-1:0]   pri;
        logic               rt;
        logic [PRI_W-1:0]   rt_pri;
        logic [AFF_W-1:0]   aff;
        logic [CPU_W-1:0]   cpu;
        bit                 wait_drain;  // hold this command until no result is outstanding
    } sched_cmd_t;

    // One result as carried on the master side.
    typedef struct {
        status_t            status;
        logic [ID_IN_W-1:0] taken;
        logic [PRI_W-1:0]   used;
        logic [PRI_W-1:0]   head;
        logic [OCC_W-1:0]   occ;
    } sched_res_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // [7:0] task_id, [22:8] priority_req, [23] realtime_req,
                                  // [38:24] rt_priority, [46:39] affinity, [49:47] cpu
    logic [1:0]  s_tuser  = '0;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [1:0] status, [9:2] taken_id, [24:10] used_priority,
                                  // [39:25] head_priority, [45:40] occupancy

    sched_cmd_t pending_cmds[$];    // commands not yet accepted, front is on the bus
    sched_res_t expected_results[$];

    // Behavioral copy of the ready queue; entry 0 is the head.
    logic [ID_IN_W-1:0] rq_task [QDEPTH];
    logic [PRI_W-1:0]   rq_pri  [QDEPTH];
    logic [AFF_W-1:0]   rq_aff  [QDEPTH];
    int                 rq_len = 0;

    int  errors    = 0;
    int  cycle_cnt = 0;
    int  hold_left = 0;
    bit  cmd_fired = 1'b0;          // command transaction at the last rising edge
    bit  calm;

    affinity_priority_ready_queue_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

    // ------------------------------------------------------------------------
    // Queue predictor
    // ------------------------------------------------------------------------

    // Drop entry pos and close the gap by moving the tail up one place.
    function automatic void drop_entry(int pos);
        int i;
        for (i = pos; i + 1 < rq_len; i++)
        begin
            rq_task[i] = rq_task[i + 1];
            rq_pri[i]  = rq_pri[i + 1];
            rq_aff[i]  = rq_aff[i + 1];
        end
        rq_len--;
    endfunction

    // Apply one accepted command to the queue copy and return its result.
    function automatic sched_res_t schedule_step(sched_cmd_t c);
        sched_res_t         r;
        logic [PRI_W-1:0]   eff;
        logic [ID_IN_W-1:0] id;
        int                 pos;
        int                 i;
        r.status = STAT_OK;
        r.taken  = '0;
        r.used   = '0;
        id       = c.task_id & ID_MASK;
        case (c.op)
            OP_INSERT:
            begin
                eff = c.rt ? c.rt_pri : c.pri;
                if (rq_len >= QDEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    // Equal priorities stay behind the older entries.
                    pos = 0;
                    while (pos < rq_len && rq_pri[pos] >= eff)
                        pos++;
                    for (i = rq_len; i > pos; i--)
                    begin
                        rq_task[i] = rq_task[i - 1];
                        rq_pri[i]  = rq_pri[i - 1];
                        rq_aff[i]  = rq_aff[i - 1];
                    end
                    rq_task[pos] = id;
                    rq_pri[pos]  = eff;
                    rq_aff[pos]  = c.aff;
                    rq_len++;
                    r.used = eff;
                end
            end
            OP_REMOVE:
            begin
                pos = 0;
                while (pos < rq_len && rq_task[pos] != id)
                    pos++;
                if (pos < rq_len)
                    drop_entry(pos);
                else
                    r.status = STAT_NOTFOUND;
            end
            OP_TAKE:
            begin
                // A CPU outside the configured count finds nothing eligible.
                pos = rq_len;
                if (c.cpu < CPUS)
                begin
                    pos = 0;
                    while (pos < rq_len && !rq_aff[pos][c.cpu])
                        pos++;
                end
                if (pos < rq_len)
                begin
                    r.taken = rq_task[pos];
                    r.used  = rq_pri[pos];
                    drop_entry(pos);
                end
                else
                    r.status = STAT_NOTFOUND;
            end
            default:
                ;  // unused opcode leaves the queue alone
        endcase
        r.head = (rq_len > 0) ? rq_pri[0] : '0;
        r.occ  = OCC_W'(rq_len);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic add_cmd(input op_t op, input logic [ID_IN_W-1:0] id,
                           input logic [PRI_W-1:0] pri, input logic rt,
                           input logic [PRI_W-1:0] rt_pri, input logic [AFF_W-1:0] aff,
                           input logic [CPU_W-1:0] cpu, input bit wait_drain = 1'b0);
        sched_cmd_t c;
        c.op         = op;
        c.task_id    = id;
        c.pri        = pri;
        c.rt         = rt;
        c.rt_pri     = rt_pri;
        c.aff        = aff;
        c.cpu        = cpu;
        c.wait_drain = wait_drain;
        pending_cmds.push_back(c);
    endtask

    // Mostly a few small values so that ties are common, else the full range
    // and its ends.
    function automatic logic [PRI_W-1:0] pick_priority();
        int r;
        r = $urandom_range(9);
        if (r < 5)
            return PRI_W'($urandom_range(7));
        else if (r < 8)
            return PRI_W'($urandom_range(32767));
        else if (r == 8)
            return '0;
        else
            return '1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. Check the result
    // first, since it belongs to an older command than any command taken at
    // the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        sched_res_t want;
        cycle_cnt++;
        cmd_fired = 1'b0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transaction, expected none, actual %0h",
                             $realtime, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status",        32'(want.status), 32'(m_tdata[1:0]));
                    check_field("taken_id",      32'(want.taken),  32'(m_tdata[9:2]));
                    check_field("used_priority", 32'(want.used),   32'(m_tdata[24:10]));
                    check_field("head_priority", 32'(want.head),   32'(m_tdata[39:25]));
                    check_field("occupancy",     32'(want.occ),    32'(m_tdata[45:40]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(schedule_step(pending_cmds.pop_front()));
                cmd_fired = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: offer the front pending command at the falling edge. Hold an
    // offered command until its transaction completes; otherwise idle at
    // random, except in the calm window.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        bit go;
        go = 1'b0;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !cmd_fired)
            ;  // hold the offered transaction
        else
        begin
            if (pending_cmds.size() != 0)
            begin
                go = calm || ($urandom_range(99) >= IDLE_PCT);
                // Pause the source until every outstanding result has come back.
                if (pending_cmds[0].wait_drain && expected_results.size() != 0)
                    go = 1'b0;
            end
            if (go)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, pending_cmds[0].cpu, pending_cmds[0].aff,
                             pending_cmds[0].rt_pri, pending_cmds[0].rt,
                             pending_cmds[0].pri, pending_cmds[0].task_id};
                s_tuser  <= pending_cmds[0].op;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Sink: stall at random, never in the calm window, and twice hold off for
    // a long stretch so the output register fills and the block stalls its
    // input while the source keeps offering.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (cycle_cnt == HOLD_AT_A || cycle_cnt == HOLD_AT_B)
        begin
            m_tready  <= 1'b0;
            hold_left = HOLD_LEN - 1;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int   mode;
        int   r;
        op_t  op;
        logic [AFF_W-1:0] aff;

        // Directed opening. Empty queue: take, remove and the unused opcode.
        add_cmd(OP_TAKE,   8'd0,   15'd0,      1'b0, 15'd0,      8'h00, 3'd0);
        add_cmd(OP_REMOVE, 8'd5,   15'd0,      1'b0, 15'd0,      8'h00, 3'd0);
        add_cmd(OP_NONE,   8'd0,   15'd0,      1'b0, 15'd0,      8'h00, 3'd0);
        // Field extremes, a real-time tie with the head, a real-time priority
        // that must be ignored, and a duplicate id.
        add_cmd(OP_INSERT, 8'd0,   15'd0,      1'b0, 15'd0,      8'h01, 3'd0);
        add_cmd(OP_INSERT, 8'd255, 15'h7fff,   1'b0, 15'd0,      8'h80, 3'd7);
        add_cmd(OP_INSERT, 8'd10,  15'd0,      1'b1, 15'h7fff,   8'hff, 3'd0);
        add_cmd(OP_INSERT, 8'd11,  15'h4000,   1'b0, 15'h7fff,   8'h00, 3'd0);
        add_cmd(OP_INSERT, 8'd10,  15'd1,      1'b0, 15'd0,      8'h02, 3'd0);
        // Takes by affinity, including a CPU that nothing may run on.
        add_cmd(OP_TAKE,   8'd0,   15'd0,      1'b0, 15'd0,      8'h00, 3'd7);
        add_cmd(OP_TAKE,   8'd0,   15'd0,      1'b0, 15'd0,      8'h00, 3'd3);
        add_cmd(OP_TAKE,   8'd0,   15'd0,      1'b0, 15'd0,      8'h00, 3'd2);
        // Remove the remaining copy of a duplicate, then miss it.
        add_cmd(OP_REMOVE, 8'd10,  15'd0,      1'b0, 15'd0,      8'h00, 3'd0);
        add_cmd(OP_REMOVE, 8'd10,  15'd0,      1'b0, 15'd0,      8'h00, 3'd0);
        add_cmd(OP_NONE,   8'hff,  15'h7fff,   1'b1, 15'h7fff,   8'hff, 3'd7);
        add_cmd(OP_TAKE,   8'd0,   15'd0,      1'b0, 15'd0,      8'h00, 3'd0);
        add_cmd(OP_REMOVE, 8'd11,  15'd0,      1'b0, 15'd0,      8'h00, 3'd0);

        // Random part in phases: fill (reaches the full table), drain
        // (reaches empty) and mixed. Ids come mostly from a small set so that
        // removes hit queued tasks and duplicates occur.
        for (int n = 0; n < N_RANDOM; n++)
        begin
            mode = (n / PHASE_LEN) % 3;
            r    = $urandom_range(99);
            if (r < 3)
                op = OP_NONE;
            else if (mode == 0)
                op = (r < 78) ? OP_INSERT : (r < 88) ? OP_REMOVE : OP_TAKE;
            else if (mode == 1)
                op = (r < 18) ? OP_INSERT : (r < 53) ? OP_REMOVE : OP_TAKE;
            else
                op = (r < 43) ? OP_INSERT : (r < 68) ? OP_REMOVE : OP_TAKE;

            r = $urandom_range(9);
            if (r < 6)
                aff = AFF_W'($urandom_range(255));
            else if (r < 8)
                aff = 8'h01 << $urandom_range(7);
            else if (r == 8)
                aff = 8'h00;
            else
                aff = 8'hff;

            add_cmd(op,
                    ID_IN_W'(($urandom_range(9) < 7) ? $urandom_range(15)
                                                     : $urandom_range(255)),
                    pick_priority(), 1'($urandom_range(1)), pick_priority(), aff,
                    CPU_W'($urandom_range(7)), (n == 0) || (n % 450 == 225));
        end

        // Hold reset, then release it away from the rising edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: end the run if the stream stops making progress.
    initial
    begin
        #LIMIT_NS;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/aprq_pkg.sv
sv/aprq_cell.sv
sv/affinity_priority_ready_queue_core.sv
tb/sv/affinity_priority_ready_queue_core_tb.sv
